FILE: rtl/core/bdq_pkg.sv
// Package with shared types, command codes and default sizes for the bounded deque store.
package bdq_pkg;

  localparam int unsigned DefaultDepth       = 256;
  localparam int unsigned DefaultPayloadBits = 32;

  typedef enum logic [2:0] {
    CMD_INSERT_HEAD = 3'd0,
    CMD_INSERT_TAIL = 3'd1,
    CMD_REMOVE_HEAD = 3'd2,
    CMD_REMOVE_TAIL = 3'd3,
    CMD_READ_POS    = 3'd4
  } cmd_e;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] entry_value;
    logic [7:0]  position;
  } in_t;

  typedef struct packed {
    logic [31:0] read_value;
    logic        read_ok;
    logic [8:0]  entry_count;
    logic        ignored;
  } out_t;

  typedef struct packed {
    logic       read_ok;
    logic [8:0] entry_count;
    logic       ignored;
  } meta_t;

endpackage

FILE: rtl/core/bdq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module bdq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/bdq_ctrl.sv
// Front pointer and count registers with the per-command address and result logic.
module bdq_ctrl #(
  parameter int unsigned DEPTH        = bdq_pkg::DefaultDepth,
  parameter int unsigned PAYLOAD_BITS = bdq_pkg::DefaultPayloadBits,
  localparam int unsigned PW          = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW          = $clog2(DEPTH + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  input  bdq_pkg::in_t            item_i,
  output logic                    we_o,
  output logic [PW-1:0]           waddr_o,
  output logic [PAYLOAD_BITS-1:0] wdata_o,
  output logic [PW-1:0]           raddr_o,
  output bdq_pkg::meta_t          meta_o
);

  localparam int unsigned SW   = PW + 1;
  localparam int unsigned RW   = ((PW > 8) ? PW : 8) + 1;
  localparam int unsigned CMPW = (CW > 8) ? CW : 8;

  logic [PW-1:0] front_q, front_d;
  logic [CW-1:0] count_q, count_d;
  logic          full, empty;
  logic [PW-1:0] front_dec, front_inc;
  logic [SW-1:0] tail_sum;
  logic [PW-1:0] tail_addr;
  logic [RW-1:0] read_sum;
  logic          read_ok;
  logic          ignored;
  logic          we;
  logic [PW-1:0] waddr;

  assign full  = (count_q == CW'(DEPTH));
  assign empty = (count_q == '0);

  assign front_dec = (front_q == '0) ? PW'(DEPTH - 1) : front_q - PW'(1);
  assign front_inc = (front_q == PW'(DEPTH - 1)) ? '0 : front_q + PW'(1);

  always_comb begin
    tail_sum = SW'(front_q) + SW'(count_q);
    if (tail_sum >= SW'(DEPTH)) begin
      tail_sum = tail_sum - SW'(DEPTH);
    end
    tail_addr = tail_sum[PW-1:0];

    read_sum = RW'(front_q) + RW'(item_i.position);
    if (read_sum >= RW'(DEPTH)) begin
      read_sum = read_sum - RW'(DEPTH);
    end
  end

  assign raddr_o = read_sum[PW-1:0];

  always_comb begin
    front_d = front_q;
    count_d = count_q;
    read_ok = 1'b0;
    ignored = 1'b0;
    we      = 1'b0;
    waddr   = tail_addr;
    unique case (item_i.command)
      bdq_pkg::CMD_INSERT_HEAD: begin
        if (full) begin
          ignored = 1'b1;
        end else begin
          front_d = front_dec;
          count_d = count_q + CW'(1);
          we      = 1'b1;
          waddr   = front_dec;
        end
      end
      bdq_pkg::CMD_INSERT_TAIL: begin
        if (full) begin
          ignored = 1'b1;
        end else begin
          count_d = count_q + CW'(1);
          we      = 1'b1;
        end
      end
      bdq_pkg::CMD_REMOVE_HEAD: begin
        if (empty) begin
          ignored = 1'b1;
        end else begin
          front_d = front_inc;
          count_d = count_q - CW'(1);
        end
      end
      bdq_pkg::CMD_REMOVE_TAIL: begin
        if (empty) begin
          ignored = 1'b1;
        end else begin
          count_d = count_q - CW'(1);
        end
      end
      bdq_pkg::CMD_READ_POS: begin
        read_ok = (CMPW'(item_i.position) < CMPW'(count_q));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
    end else if (accept_i) begin
      front_q <= front_d;
      count_q <= count_d;
    end
  end

  assign we_o                = accept_i && we;
  assign waddr_o             = waddr;
  assign wdata_o             = PAYLOAD_BITS'(item_i.entry_value);
  assign meta_o.read_ok      = read_ok;
  assign meta_o.entry_count  = 9'(count_d);
  assign meta_o.ignored      = ignored;

endmodule

FILE: rtl/core/bounded_deque_store_core.sv
// Top level of the bounded deque store: circular entry RAM, control and result pipeline.
// The RAM read data and metadata are registered in the read stage, then go to the result register.
// Throughput: one transaction per cycle while results are taken, set by the single RAM write and read port.
// While a result waits, one more transaction enters the read stage, then the input stalls.
// Reset clears the front pointer, the count and the pipeline valid bits at once.
// The entry RAM is not cleared; only written entries are ever reported.
module bounded_deque_store_core #(
  parameter int unsigned DEPTH        = bdq_pkg::DefaultDepth,
  parameter int unsigned PAYLOAD_BITS = bdq_pkg::DefaultPayloadBits
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  bdq_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output bdq_pkg::out_t out_data_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                    accept;
  logic                    s1_adv;
  logic                    we;
  logic [PW-1:0]           waddr;
  logic [PAYLOAD_BITS-1:0] wdata;
  logic [PW-1:0]           raddr;
  logic [PAYLOAD_BITS-1:0] rdata;
  bdq_pkg::meta_t          meta;

  logic           s1_valid_q;
  bdq_pkg::meta_t s1_meta_q;
  logic           out_valid_q;
  bdq_pkg::out_t  out_q;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign accept     = in_valid_i && in_ready_o;

  bdq_ctrl #(
    .DEPTH        (DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_data_i),
    .we_o     (we),
    .waddr_o  (waddr),
    .wdata_o  (wdata),
    .raddr_o  (raddr),
    .meta_o   (meta)
  );

  bdq_ram #(
    .WIDTH (PAYLOAD_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (accept),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_meta_q <= meta;
    end
    if (s1_adv) begin
      out_q.read_value  <= s1_meta_q.read_ok ? 32'(rdata) : '0;
      out_q.read_ok     <= s1_meta_q.read_ok;
      out_q.entry_count <= s1_meta_q.entry_count;
      out_q.ignored     <= s1_meta_q.ignored;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
